// ----- hdl/plg_pkg.sv -----
package plg_pkg;

  // Largest password the gate can hold, in characters.
  localparam int PASSWORD_MAX_CHARS = 16;
  localparam logic [4:0] MAX_LEN = 5'(PASSWORD_MAX_CHARS);
  localparam logic [4:0] TYPED_COUNT_MAX = 5'd31;
  localparam logic [15:0] DELAY_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    KIND_CHAR     = 2'd0,
    KIND_EOL      = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_LOCK_REQ = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_UNLOCKED    = 3'd1,
    EV_WRONG       = 3'd2,
    EV_LOCKOUT     = 3'd3,
    EV_AUTO_LOCKED = 3'd4,
    EV_REQ_LOCKED  = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    REG_PWD_LOW      = 3'd0,
    REG_PWD_HIGH     = 3'd1,
    REG_PWD_LENGTH   = 3'd2,
    REG_ATTEMPTS     = 3'd3,
    REG_SHORT_DELAY  = 3'd4,
    REG_LONG_DELAY   = 3'd5,
    REG_AUTO_LOCK    = 3'd6,
    REG_UNUSED       = 3'd7
  } reg_index_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  char_value;
  } item_t;

  typedef struct packed {
    logic        locked;
    event_t      event_res;
    logic        disconnect;
    logic        blocked;
  } result_t;

endpackage

// ----- hdl/password_lock_gate.sv -----
// Password gate with brute-force throttling. Items (characters, ends of line, 1 ms ticks and
// lock requests) enter through a one-deep input register and each yields exactly one result
// beat; the state update and the result are computed together between the input register and
// the result register, so the gate takes one item per clock while the result side does not
// stall, and a result beat is presented from the result register after its item has passed
// through the input register. That path holds the state update: a byte compare, a 17-bit
// delay sum and the 32-bit idle decrement.
// Configuration writes are always ready and take effect on the next cycle; writing the
// attempts register also reloads the remaining attempts. The gate leaves reset locked.
module password_lock_gate (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  plg_pkg::item_t           item,
  output logic                     result_valid,
  input  logic                     result_stall,
  output plg_pkg::result_t         result,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [2:0]               cfg_index,
  input  logic [63:0]              cfg_data
);

  // Configuration registers.
  logic [63:0] pwd_low;
  logic [63:0] pwd_high;
  logic [4:0]  pwd_length;
  logic [3:0]  attempts_cfg;
  logic [15:0] short_delay;
  logic [15:0] long_delay;
  logic [31:0] auto_lock_timeout;

  // Gate state.
  logic        lock_flag;
  logic        mismatch_seen;
  logic [4:0]  typed_count;
  logic [3:0]  attempts_left;
  logic [15:0] delay_remaining;
  logic [31:0] idle_remaining;

  logic        lock_flag_next;
  logic        mismatch_seen_next;
  logic [4:0]  typed_count_next;
  logic [3:0]  attempts_left_next;
  logic [15:0] delay_remaining_next;
  logic [31:0] idle_remaining_next;

  logic             item_full;
  plg_pkg::item_t   item_held;
  plg_pkg::result_t result_next;
  logic             advance;
  logic             cfg_write;

  logic [4:0]   eff_len;
  logic [3:0]   eff_attempts;
  logic [3:0]   cfg_attempts_eff;
  logic [127:0] pwd_bits;
  logic [7:0]   pwd_char;
  logic [16:0]  delay_sum;
  logic [31:0]  idle_dec;

  assign cfg_ready  = 1'b1;
  assign cfg_write  = cfg_valid && cfg_ready;
  assign advance    = item_full && (!result_valid || !result_stall);
  assign item_stall = item_full && !advance;

  assign eff_len          = (pwd_length > plg_pkg::MAX_LEN) ? plg_pkg::MAX_LEN : pwd_length;
  assign eff_attempts     = (attempts_cfg == 4'd0) ? 4'd1 : attempts_cfg;
  assign cfg_attempts_eff = (cfg_data[3:0] == 4'd0) ? 4'd1 : cfg_data[3:0];
  assign pwd_bits         = {pwd_high, pwd_low};
  assign pwd_char         = pwd_bits[{typed_count[3:0], 3'b000} +: 8];
  assign delay_sum        = {1'b0, short_delay} + {1'b0, long_delay};
  assign idle_dec         = idle_remaining - 32'd1;

  always_comb begin
    lock_flag_next       = lock_flag;
    mismatch_seen_next   = mismatch_seen;
    typed_count_next     = typed_count;
    attempts_left_next   = attempts_left;
    delay_remaining_next = delay_remaining;
    idle_remaining_next  = idle_remaining;
    result_next          = '0;
    result_next.event_res = plg_pkg::EV_NONE;

    unique case (item_held.kind)
      plg_pkg::KIND_CHAR: begin
        if (delay_remaining == 16'd0) begin
          if (lock_flag) begin
            if (typed_count >= eff_len || pwd_char != item_held.char_value) begin
              mismatch_seen_next = 1'b1;
            end
          end
          if (typed_count < plg_pkg::TYPED_COUNT_MAX) begin
            typed_count_next = typed_count + 5'd1;
          end
        end
      end
      plg_pkg::KIND_EOL: begin
        if (delay_remaining == 16'd0 && typed_count != 5'd0) begin
          if (lock_flag) begin
            if (!mismatch_seen && typed_count == eff_len) begin
              lock_flag_next        = 1'b0;
              result_next.event_res = plg_pkg::EV_UNLOCKED;
              attempts_left_next    = eff_attempts;
              idle_remaining_next   = auto_lock_timeout;
            end else if (attempts_left <= 4'd1) begin
              delay_remaining_next   = delay_sum[16] ? plg_pkg::DELAY_MAX : delay_sum[15:0];
              attempts_left_next     = eff_attempts;
              result_next.event_res  = plg_pkg::EV_LOCKOUT;
              result_next.disconnect = 1'b1;
            end else begin
              attempts_left_next    = attempts_left - 4'd1;
              delay_remaining_next  = short_delay;
              result_next.event_res = plg_pkg::EV_WRONG;
            end
          end else begin
            idle_remaining_next = auto_lock_timeout;
          end
          typed_count_next   = 5'd0;
          mismatch_seen_next = 1'b0;
        end
      end
      plg_pkg::KIND_TICK: begin
        if (delay_remaining != 16'd0) begin
          delay_remaining_next = delay_remaining - 16'd1;
        end
        if (!lock_flag && auto_lock_timeout != 32'd0 && idle_remaining != 32'd0) begin
          idle_remaining_next = idle_dec;
          if (idle_dec == 32'd0) begin
            lock_flag_next         = 1'b1;
            typed_count_next       = 5'd0;
            mismatch_seen_next     = 1'b0;
            result_next.event_res  = plg_pkg::EV_AUTO_LOCKED;
            result_next.disconnect = 1'b1;
          end
        end
      end
      plg_pkg::KIND_LOCK_REQ: begin
        if (!lock_flag) begin
          lock_flag_next        = 1'b1;
          idle_remaining_next   = 32'd0;
          typed_count_next      = 5'd0;
          mismatch_seen_next    = 1'b0;
          result_next.event_res = plg_pkg::EV_REQ_LOCKED;
        end
      end
      default: begin
      end
    endcase

    result_next.locked  = lock_flag_next;
    result_next.blocked = (delay_remaining_next != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwd_low           <= '0;
      pwd_high          <= '0;
      pwd_length        <= '0;
      attempts_cfg      <= 4'd3;
      short_delay       <= 16'd1000;
      long_delay        <= 16'd7000;
      auto_lock_timeout <= '0;
    end else if (cfg_write) begin
      unique case (plg_pkg::reg_index_t'(cfg_index))
        plg_pkg::REG_PWD_LOW:     pwd_low           <= cfg_data;
        plg_pkg::REG_PWD_HIGH:    pwd_high          <= cfg_data;
        plg_pkg::REG_PWD_LENGTH:  pwd_length        <= cfg_data[4:0];
        plg_pkg::REG_ATTEMPTS:    attempts_cfg      <= cfg_data[3:0];
        plg_pkg::REG_SHORT_DELAY: short_delay       <= cfg_data[15:0];
        plg_pkg::REG_LONG_DELAY:  long_delay        <= cfg_data[15:0];
        plg_pkg::REG_AUTO_LOCK:   auto_lock_timeout <= cfg_data[31:0];
        plg_pkg::REG_UNUSED: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lock_flag       <= 1'b1;
      mismatch_seen   <= 1'b0;
      typed_count     <= '0;
      attempts_left   <= 4'd3;
      delay_remaining <= '0;
      idle_remaining  <= '0;
    end else begin
      if (advance) begin
        lock_flag       <= lock_flag_next;
        mismatch_seen   <= mismatch_seen_next;
        typed_count     <= typed_count_next;
        delay_remaining <= delay_remaining_next;
        idle_remaining  <= idle_remaining_next;
      end
      // A write of the attempts register reloads the count straight away.
      if (cfg_write && cfg_index == plg_pkg::REG_ATTEMPTS) begin
        attempts_left <= cfg_attempts_eff;
      end else if (advance) begin
        attempts_left <= attempts_left_next;
      end
    end
  end

  // Input register: holds one beat until the result register can take its result.
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (item_valid && !item_stall) begin
      item_full <= 1'b1;
    end else if (advance) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      item_held <= item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

endmodule

// ----- hdl/plg_checker.sv -----
module plg_checker (
  input logic               clk,
  input logic               rst,
  input logic               item_valid,
  input logic               item_stall,
  input plg_pkg::item_t     item,
  input logic               result_valid,
  input logic               result_stall,
  input plg_pkg::result_t   result,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [63:0]        cfg_data
);

  // A result beat held back by stall must stay put.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result beat changed");

  // Disconnect only comes with a lockout or an automatic relock.
  a_disconnect_cause: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.disconnect |->
      result.event_res == plg_pkg::EV_LOCKOUT || result.event_res == plg_pkg::EV_AUTO_LOCKED)
    else $error("disconnect without lockout or auto lock");

  // The lock state reported must agree with the event of the same beat.
  a_event_lock_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.event_res != plg_pkg::EV_NONE |->
      (result.event_res == plg_pkg::EV_UNLOCKED) == !result.locked)
    else $error("event and locked flag disagree");

  // No result beat can appear in the cycle after reset.
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat straight after reset");

endmodule

bind password_lock_gate plg_checker u_plg_checker (.*);
